FILE: src/arcf_pkg.sv
package arcf_pkg;

  localparam int unsigned CpWidth    = 21;
  localparam int unsigned DropRanges = 13;
  localparam int unsigned AddrWidth  = 3;

  localparam logic [CpWidth-1:0] ChAlef = 21'h000627;
  localparam logic [CpWidth-1:0] ChWaw  = 21'h000648;
  localparam logic [CpWidth-1:0] ChYeh  = 21'h00064A;

  localparam logic [1:0] RunMax = 2'd3;

  localparam logic [0:0] RegCollapseEnable = 1'b0;

  localparam logic [CpWidth-1:0] DropLo [DropRanges] = '{
    21'h000600, 21'h000610, 21'h000617, 21'h000640, 21'h00064B, 21'h00066C, 21'h000670,
    21'h0006A4, 21'h0006D6, 21'h0006DF, 21'h0006E7, 21'h0006EA, 21'h00FBB2
  };
  localparam logic [CpWidth-1:0] DropHi [DropRanges] = '{
    21'h000603, 21'h000615, 21'h00061A, 21'h000640, 21'h000655, 21'h00066C, 21'h000671,
    21'h0006A4, 21'h0006DD, 21'h0006E4, 21'h0006E8, 21'h0006ED, 21'h00FBC1
  };

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               word_start;
  } in_t;

  typedef struct packed {
    logic [CpWidth-1:0] out_char;
    logic [1:0]         retract_count;
  } out_t;

  typedef struct packed {
    logic       dropped;
    logic [1:0] limit;
  } class_t;

endpackage

FILE: src/arcf_classify.sv
module arcf_classify import arcf_pkg::*; (
  input  logic [CpWidth-1:0] cp_i,
  output class_t             class_o
);

  logic [DropRanges-1:0] hit;

  always_comb begin
    for (int i = 0; i < DropRanges; i++) begin
      hit[i] = (cp_i >= DropLo[i]) && (cp_i <= DropHi[i]);
    end
  end

  always_comb begin
    class_o.dropped = |hit;
    if (cp_i == ChAlef) begin
      class_o.limit = 2'd1;
    end else if (cp_i == ChWaw || cp_i == ChYeh) begin
      class_o.limit = 2'd2;
    end else begin
      class_o.limit = 2'd0;
    end
  end

endmodule

FILE: src/arabic_char_filter_run_collapse.sv
// An accepted beat is held in the input register, then moves on to the result register,
// from which its result beat is offered. Throughput: one beat per cycle unless out_ready_i
// stalls the output, set by the input register feeding the result register.
// Dropped characters take a slot in the input register but produce no output beat.
// Reset (rst_ni low, asynchronous) clears valid flags, run tracking and collapse_enable.
// The configuration register reads back on prdata; pready is always high.
module arabic_char_filter_run_collapse import arcf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic               s1_valid_q;
  in_t                s1_data_q;
  logic               out_valid_q;
  out_t               out_data_q, out_data_d;
  logic               enable_q;
  logic [CpWidth-1:0] prev_q, prev_d;
  logic [1:0]         run_q, run_d;
  logic               has_q, has_d;
  logic               advance;
  logic               reg_sel;
  class_t             cls;

  assign reg_sel = (paddr[AddrWidth-1] == RegCollapseEnable);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {31'd0, enable_q} : 32'd0;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  arcf_classify u_classify (
    .cp_i    (s1_data_q.code_point),
    .class_o (cls)
  );

  always_comb begin
    logic       has_eff;
    logic [1:0] run_inc;
    has_eff = has_q && !s1_data_q.word_start;
    run_inc = (run_q == RunMax) ? RunMax : run_q + 2'd1;
    prev_d  = prev_q;
    run_d   = run_q;
    has_d   = has_eff;
    out_data_d.out_char      = s1_data_q.code_point;
    out_data_d.retract_count = 2'd0;
    if (!cls.dropped) begin
      has_d = 1'b1;
      if (enable_q) begin
        prev_d = s1_data_q.code_point;
        if (has_eff && prev_q == s1_data_q.code_point) begin
          run_d = run_inc;
          if (cls.limit != 2'd0) begin
            if (run_inc == cls.limit) begin
              out_data_d.retract_count = cls.limit;
            end else if (run_inc > cls.limit) begin
              out_data_d.retract_count = 2'd1;
            end
          end
        end else begin
          run_d = 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      enable_q    <= 1'b0;
      prev_q      <= '0;
      run_q       <= '0;
      has_q       <= 1'b0;
    end else begin
      if (psel && penable && pwrite && reg_sel) begin
        enable_q <= pwdata[0];
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        prev_q      <= prev_d;
        run_q       <= run_d;
        has_q       <= has_d;
        out_valid_q <= !cls.dropped;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
    if (advance && !cls.dropped) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_retract_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.retract_count != RunMax)
    else $error("retract count out of range");

  a_retract_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.retract_count != 2'd0) |->
      (out_data_o.out_char == ChAlef || out_data_o.out_char == ChWaw ||
       out_data_o.out_char == ChYeh))
    else $error("retract on a character that does not collapse");

  a_retract_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.retract_count == 2'd2) |->
      (out_data_o.out_char == ChWaw || out_data_o.out_char == ChYeh))
    else $error("double retract on a character other than waw or yeh");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while the pipeline is stalled");
`endif

endmodule

FILE: tb/arabic_char_filter_run_collapse_tb.sv
`timescale 1ns / 1ps

module arabic_char_filter_run_collapse_tb;
  import arcf_pkg::*;

  typedef enum logic [1:0] {ChkPredict, ChkNone, ChkGiven} chk_e;

  typedef struct packed {
    logic  collapse;
    in_t   beat;
    chk_e  chk;
    out_t  given;
  } row_t;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 150;
  localparam int PhaseChars = 66;
  localparam logic [AddrWidth-1:0] CollapseAddr = AddrWidth'(4 * RegCollapseEnable);

  localparam int NumRows = 27;
  localparam row_t DirectedRows [NumRows] = '{
    '{1'b0, '{21'h000000, 1'b1}, ChkGiven, '{21'h000000, 2'd0}},
    '{1'b0, '{21'h1FFFFF, 1'b0}, ChkGiven, '{21'h1FFFFF, 2'd0}},
    '{1'b0, '{21'h10FFFF, 1'b0}, ChkGiven, '{21'h10FFFF, 2'd0}},
    '{1'b0, '{21'h000600, 1'b0}, ChkNone, '0},
    '{1'b0, '{21'h00FBC1, 1'b1}, ChkNone, '0},
    '{1'b0, '{21'h000604, 1'b0}, ChkGiven, '{21'h000604, 2'd0}},
    '{1'b0, '{21'h000627, 1'b1}, ChkGiven, '{21'h000627, 2'd0}},
    '{1'b0, '{21'h000627, 1'b0}, ChkGiven, '{21'h000627, 2'd0}},
    '{1'b1, '{21'h000627, 1'b1}, ChkGiven, '{21'h000627, 2'd0}},
    '{1'b1, '{21'h000627, 1'b0}, ChkPredict, '0},
    '{1'b1, '{21'h00064B, 1'b0}, ChkNone, '0},
    '{1'b1, '{21'h000627, 1'b0}, ChkPredict, '0},
    '{1'b1, '{21'h000648, 1'b1}, ChkPredict, '0},
    '{1'b1, '{21'h000648, 1'b0}, ChkPredict, '0},
    '{1'b1, '{21'h000648, 1'b0}, ChkPredict, '0},
    '{1'b1, '{21'h000648, 1'b0}, ChkPredict, '0},
    '{1'b1, '{21'h000648, 1'b0}, ChkPredict, '0},
    '{1'b1, '{21'h00064A, 1'b1}, ChkPredict, '0},
    '{1'b1, '{21'h000640, 1'b1}, ChkNone, '0},
    '{1'b1, '{21'h00064A, 1'b0}, ChkPredict, '0},
    '{1'b1, '{21'h00064A, 1'b0}, ChkPredict, '0},
    '{1'b1, '{21'h000628, 1'b0}, ChkPredict, '0},
    '{1'b1, '{21'h000628, 1'b0}, ChkPredict, '0},
    '{1'b0, '{21'h00064A, 1'b0}, ChkGiven, '{21'h00064A, 2'd0}},
    '{1'b1, '{21'h00064A, 1'b0}, ChkPredict, '0},
    '{1'b1, '{21'h0006ED, 1'b0}, ChkNone, '0},
    '{1'b1, '{21'h00FBB2, 1'b0}, ChkNone, '0}
  };

  bit                   clk;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_t                  in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_t                 out_data_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  logic               collapse_on;
  logic [CpWidth-1:0] last_kept;
  logic [1:0]         repeat_cnt;
  logic               in_word;

  out_t pending_chars [$];
  out_t want;
  int   errors;
  int   kept_count;
  int   cycle_count;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   hold_requests;
  int   hold_served;
  int   hold_left;

  arabic_char_filter_run_collapse dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("arabic_char_filter_run_collapse_tb: done, errors");
      $finish;
    end
  end

  function automatic bit in_drop_set(logic [CpWidth-1:0] cp);
    for (int i = 0; i < DropRanges; i++) begin
      if (cp >= DropLo[i] && cp <= DropHi[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [CpWidth-1:0] any_dropped();
    int idx;
    idx = $urandom_range(DropRanges - 1);
    return DropLo[idx] + CpWidth'($urandom_range(DropHi[idx] - DropLo[idx]));
  endfunction

  function automatic bit filter_char(input in_t beat, output out_t res);
    logic [1:0] limit;
    logic [1:0] retract;
    retract = 2'd0;
    res = '0;
    if (beat.word_start) in_word = 1'b0;
    if (in_drop_set(beat.code_point)) return 1'b0;
    if (collapse_on) begin
      if (!in_word) begin
        repeat_cnt = 2'd0;
      end else if (last_kept == beat.code_point) begin
        if (beat.code_point == ChAlef) limit = 2'd1;
        else if (beat.code_point == ChWaw || beat.code_point == ChYeh) limit = 2'd2;
        else limit = 2'd0;
        if (repeat_cnt < RunMax) repeat_cnt++;
        if (limit != 2'd0) begin
          if (repeat_cnt == limit) retract = limit;
          else if (repeat_cnt > limit) retract = 2'd1;
        end
      end else begin
        repeat_cnt = 2'd0;
      end
      last_kept = beat.code_point;
    end
    in_word = 1'b1;
    res.out_char = beat.code_point;
    res.retract_count = retract;
    return 1'b1;
  endfunction

  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected out beat: out_char %h retract_count %0d",
               out_data_o.out_char, out_data_o.retract_count);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        if (out_data_o.out_char !== want.out_char) begin
          $error("out_char: expected %h, actual %h", want.out_char, out_data_o.out_char);
          errors++;
        end
        if (out_data_o.retract_count !== want.retract_count) begin
          $error("retract_count: expected %0d, actual %0d",
                 want.retract_count, out_data_o.retract_count);
          errors++;
        end
      end
    end
  end

  task automatic send_char(input in_t beat, input chk_e chk, input out_t given);
    out_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk);
    end
    in_valid_i = 1'b1;
    in_data_i = beat;
    do @(posedge clk); while (!in_ready_o);
    if (filter_char(beat, res)) begin
      kept_count++;
      pending_chars.push_back(chk == ChkGiven ? given : res);
    end
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [AddrWidth-1:0] addr, input logic [31:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == CollapseAddr) collapse_on = data[0];
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, collapse_on}) begin
      $error("collapse_enable: expected %h, actual %h", {31'b0, collapse_on}, prdata);
      errors++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic send_word();
    int           segs;
    int           reps;
    int           pick;
    logic [CpWidth-1:0] cp;
    logic         first;
    first = 1'b1;
    segs = $urandom_range(1, 4);
    for (int s = 0; s < segs; s++) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_char('{CpWidth'($urandom), 1'($urandom_range(1))}, ChkPredict, '0);
        continue;
      end
      if (pick < 35) cp = ChAlef;
      else if (pick < 55) cp = ChWaw;
      else if (pick < 75) cp = ChYeh;
      else if (pick < 90) cp = 21'h000621 + CpWidth'($urandom_range(41));
      else cp = CpWidth'($urandom);
      reps = $urandom_range(1, 5);
      for (int r = 0; r < reps; r++) begin
        if ($urandom_range(3) == 0) begin
          send_char('{any_dropped(), first | ($urandom_range(15) == 0)}, ChkPredict, '0);
          first = 1'b0;
        end
        send_char('{cp, first}, ChkPredict, '0);
        first = 1'b0;
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    collapse_on = 1'b0;
    last_kept = '0;
    repeat_cnt = '0;
    in_word = 1'b0;
    tx_idle_pct = 9;
    rx_idle_pct = 63;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    for (int i = 0; i < NumRows; i++) begin
      if (DirectedRows[i].collapse != collapse_on) begin
        wait_idle();
        cfg_write(CollapseAddr, {31'b0, DirectedRows[i].collapse});
      end
      send_char(DirectedRows[i].beat, DirectedRows[i].chk, DirectedRows[i].given);
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 63 : 0;
      rx_idle_pct = (ph == 0) ? 63 : (ph == 1) ? 9 : 0;
      for (int half = 0; half < 2; half++) begin
        wait_idle();
        cfg_write(CollapseAddr, {31'b0, (half == 0)});
        // Stall the output for a long stretch while beats keep coming in.
        if (ph == 0 && half == 0) hold_requests <= hold_requests + 1;
        kept_count = 0;
        while (kept_count < PhaseChars) begin
          send_word();
          if (ph == 1 && half == 0 && kept_count >= PhaseChars / 2 && kept_count < 50) begin
            wait_idle();
          end
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("arabic_char_filter_run_collapse_tb: done, clean");
    end else begin
      $display("arabic_char_filter_run_collapse_tb: done, errors");
    end
    $finish;
  end

endmodule
